>>> hdl/mquf_pkg.sv
// Shared types and codes for the multi-class urgent-to-front queue bank.
`default_nettype none

package mquf_pkg;

    localparam int IDX_W   = 5;
    localparam int ID_W    = 16;
    localparam int COUNT_W = 4;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TAKE = 1'b1;

    typedef enum logic [1:0] {
        RC_OK    = 2'd0,
        RC_FULL  = 2'd1,
        RC_EMPTY = 2'd2,
        RC_BAD   = 2'd3
    } t_result_code;

    typedef struct packed {
        logic                 wr;
        logic                 rd;
        t_result_code         code;
        logic [COUNT_W-1:0]   count;
    } t_ring_op;

endpackage

`default_nettype wire

>>> hdl/mquf_ring_ctrl.sv
// Head and count bookkeeping for every class ring, with slot selection for one word.
`default_nettype none

module mquf_ring_ctrl #(
    parameter int NUM_QUEUES  = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int ADDR_W      = 7
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_advance,
    input  wire logic                      i_action,
    input  wire logic [mquf_pkg::IDX_W-1:0] i_queue_index,
    input  wire logic                      i_urgent,
    output mquf_pkg::t_ring_op             o_op,
    output logic [ADDR_W-1:0]              o_addr
);

    localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;
    localparam logic [mquf_pkg::IDX_W:0] NQ_LIM = (mquf_pkg::IDX_W + 1)'(NUM_QUEUES);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(QUEUE_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_DEPTH - 1);
    localparam logic [SUM_W-1:0]  SUM_DEPTH = SUM_W'(QUEUE_DEPTH);

    logic [SLOT_W-1:0] r_head  [NUM_QUEUES];
    logic [CNT_W-1:0]  r_count [NUM_QUEUES];

    logic [SLOT_W-1:0]          n_head;
    logic [CNT_W-1:0]           n_count;
    logic                       q_bad;
    logic [QW-1:0]              qi;
    logic [SLOT_W-1:0]          head;
    logic [CNT_W-1:0]           cnt;
    logic [SLOT_W-1:0]          head_dec;
    logic [SLOT_W-1:0]          head_inc;
    logic [SUM_W-1:0]           tail_sum;
    logic [SUM_W-1:0]           tail_wrap;
    logic [SLOT_W-1:0]          slot;
    logic [CNT_W+3:0]           cnt_ext;

    assign q_bad     = {1'b0, i_queue_index} >= NQ_LIM;
    assign qi        = i_queue_index[QW-1:0];
    assign head      = r_head[qi];
    assign cnt       = r_count[qi];
    assign head_dec  = (head == '0) ? SLOT_LAST : head - 1'b1;
    assign head_inc  = (head == SLOT_LAST) ? '0 : head + 1'b1;
    assign tail_sum  = SUM_W'(head) + SUM_W'(cnt);
    assign tail_wrap = (tail_sum >= SUM_DEPTH) ? tail_sum - SUM_DEPTH : tail_sum;
    assign cnt_ext   = {4'b0000, n_count};

    always_comb begin
        n_head     = head;
        n_count    = cnt;
        slot       = head;
        o_op.wr    = 1'b0;
        o_op.rd    = 1'b0;
        o_op.code  = mquf_pkg::RC_OK;
        if (q_bad) begin
            o_op.code = mquf_pkg::RC_BAD;
        end else begin
            case (i_action)
                mquf_pkg::ACT_ADD: begin
                    if (cnt >= CNT_FULL) begin
                        o_op.code = mquf_pkg::RC_FULL;
                    end else begin
                        o_op.wr = 1'b1;
                        n_count = cnt + 1'b1;
                        if (i_urgent) begin
                            n_head = head_dec;
                            slot   = head_dec;
                        end else begin
                            slot = tail_wrap[SLOT_W-1:0];
                        end
                    end
                end
                mquf_pkg::ACT_TAKE: begin
                    if (cnt == '0) begin
                        o_op.code = mquf_pkg::RC_EMPTY;
                    end else begin
                        o_op.rd = 1'b1;
                        n_count = cnt - 1'b1;
                        n_head  = head_inc;
                    end
                end
                default: begin
                    o_op.code = mquf_pkg::RC_BAD;
                end
            endcase
        end
        o_op.count = q_bad ? '0 : cnt_ext[3:0];
    end

    assign o_addr = ADDR_W'(ADDR_W'(qi) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_QUEUES; k++) begin
                r_head[k]  <= '0;
                r_count[k] <= '0;
            end
        end else if (i_advance && !q_bad) begin
            r_head[qi]  <= n_head;
            r_count[qi] <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> hdl/multi_queue_urgent_to_front.sv
// Top level of the bank of bounded class queues with urgent insertion at the head.
//
//  Channel  | Direction | Handshake        | Word
//  request  | in        | i_valid/o_stall  | i_action, i_queue_index, i_entry_id, i_urgent
//  result   | out       | o_valid/i_stall  | o_result_code, o_served_id, o_served_urgent,
//           |           |                  | o_queue_count
//
// A request word is registered, then resolved against the ring state and the slot memory
// when the first stage advances, and its result is registered into the output stage.
// One word is accepted in every cycle while the result side does not stall; the single-port
// slot memory and the per-class head and count update set that rate.
// Reset clears all heads and counts at once; slot contents are not cleared.
// A stalled result holds both stages, and the request side then stalls in turn.
`default_nettype none

module multi_queue_urgent_to_front #(
    parameter int NUM_QUEUES  = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_WIDTH    = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic                         i_action,
    input  wire logic [mquf_pkg::IDX_W-1:0]   i_queue_index,
    input  wire logic [mquf_pkg::ID_W-1:0]    i_entry_id,
    input  wire logic                         i_urgent,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [1:0]                        o_result_code,
    output logic [mquf_pkg::ID_W-1:0]         o_served_id,
    output logic                              o_served_urgent,
    output logic [mquf_pkg::COUNT_W-1:0]      o_queue_count
);

    localparam int STORE_W = (ID_WIDTH < mquf_pkg::ID_W) ? ID_WIDTH : mquf_pkg::ID_W;
    localparam int SLOTS   = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [mquf_pkg::COUNT_W-1:0] FULL_COUNT = mquf_pkg::COUNT_W'(QUEUE_DEPTH);

    logic                          r_s1_v;
    logic                          r_s1_action;
    logic [mquf_pkg::IDX_W-1:0]    r_s1_qidx;
    logic [STORE_W-1:0]            r_s1_id;
    logic                          r_s1_urg;

    logic                          r_out_v;
    mquf_pkg::t_result_code        r_out_code;
    logic [mquf_pkg::COUNT_W-1:0]  r_out_count;
    logic                          r_out_served;
    logic [STORE_W:0]              r_rd_word;

    logic [STORE_W:0]              r_slot_mem [SLOTS];

    logic                          out_ready;
    logic                          s1_advance;
    logic                          in_accept;
    mquf_pkg::t_ring_op            op;
    logic [ADDR_W-1:0]             addr;
    logic [STORE_W+mquf_pkg::ID_W-1:0] id_ext;

    assign out_ready  = !r_out_v || !i_stall;
    assign s1_advance = r_s1_v && out_ready;
    assign o_stall    = r_s1_v && !out_ready;
    assign in_accept  = i_valid && !o_stall;

    mquf_ring_ctrl #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ring_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (s1_advance),
        .i_action      (r_s1_action),
        .i_queue_index (r_s1_qidx),
        .i_urgent      (r_s1_urg),
        .o_op          (op),
        .o_addr        (addr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (!o_stall) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_action <= i_action;
            r_s1_qidx   <= i_queue_index;
            r_s1_id     <= i_entry_id[STORE_W-1:0];
            r_s1_urg    <= i_urgent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_ready) begin
            r_out_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_code   <= op.code;
            r_out_count  <= op.count;
            r_out_served <= op.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && op.wr) begin
            r_slot_mem[addr] <= {r_s1_urg, r_s1_id};
        end
        if (s1_advance && op.rd) begin
            r_rd_word <= r_slot_mem[addr];
        end
    end

    assign id_ext          = {{mquf_pkg::ID_W{1'b0}}, r_rd_word[STORE_W-1:0]};
    assign o_valid         = r_out_v;
    assign o_result_code   = r_out_code;
    assign o_queue_count   = r_out_count;
    assign o_served_id     = r_out_served ? id_ext[mquf_pkg::ID_W-1:0] : '0;
    assign o_served_urgent = r_out_served ? r_rd_word[STORE_W] : 1'b0;

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_v && r_out_v))
        else $error("request stall raised without both stages occupied");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_v)
        else $error("accepted request word was lost");

    a_no_serve_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_code != mquf_pkg::RC_OK) |-> (o_served_id == '0 && !o_served_urgent))
        else $error("served fields set on a failed request");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_code == mquf_pkg::RC_FULL) |-> (o_queue_count == FULL_COUNT))
        else $error("full result without a full count");

    a_bad_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out_code == mquf_pkg::RC_BAD || r_out_code == mquf_pkg::RC_EMPTY))
        |-> (o_queue_count == '0))
        else $error("nonzero count on a bad index or an empty take");

endmodule

`default_nettype wire
